// File: design/imhdk_pkg.sv
`default_nettype none
package imhdk_pkg;

  // Update outcome codes reported with each result
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOWER  = 2'd1,
    ACT_SAME   = 2'd2,
    ACT_POP    = 2'd3
  } act_e;

  // Per-point status tag stored next to the heap position
  typedef enum logic [1:0] {
    TAG_UNVISITED = 2'd0,
    TAG_PROCESSED = 2'd1,
    TAG_QUEUED    = 2'd2
  } tag_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_URD, ST_UDEC, ST_SUCHK, ST_SURP, ST_SUCMP,
    ST_PRD, ST_PTOP, ST_PLAST, ST_PKEY, ST_SDCHK, ST_SDL, ST_SDR,
    ST_SDRR, ST_SDCMP, ST_PLACE, ST_DONE
  } state_e;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_URD, OP_UDEC, OP_SUCHK, OP_SURP, OP_SUCMP,
    OP_PRD, OP_PTOP, OP_PLAST, OP_PKEY, OP_SDCHK, OP_SDL, OP_SDR,
    OP_SDRR, OP_SDCMP, OP_PLACE, OP_DONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic is_pop;
    logic clr_last;
    logic pt_ok;
    logic do_lower;
    logic do_insert;
    logic pos_zero;
    logic up_stop;
    logic cnt_zero;
    logic cnt_one;
    logic at_leaf;
    logic has_right;
    logic down_stop;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: design/indexed_min_heap_decrease_key.sv
// An update reads the point's status and reach and, if it inserts the point or lowers its
// key, climbs level by level until it stops or reaches the root, then places the point. A pop
// reports empty, takes the last point, or moves the last point to the root and sinks it level
// by level, also comparing the right child where one exists. Throughput: one transaction at a time,
// the next accepted in the cycle after the result register loads.
// Reset: a clearing pass over all min(CAPACITY, 1024) points first marks every point unvisited.
`default_nettype none
module indexed_min_heap_decrease_key #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [9:0]         point_index_i,
  input  logic [31:0]        reach_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         popped_point_o,
  output logic               list_empty_o,
  output logic [1:0]         update_action_o,
  output logic [10:0]        queue_count_o
);
  import imhdk_pkg::*;

  cmd_t    cmd;
  status_t sts;
  act_e    act;

  imhdk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  imhdk_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .point_index_i   (point_index_i),
    .reach_value_i   (reach_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .popped_point_o  (popped_point_o),
    .list_empty_o    (list_empty_o),
    .update_action_o (act),
    .queue_count_o   (queue_count_o)
  );

  assign update_action_o = act;

endmodule
`default_nettype wire

// File: design/imhdk_ctrl.sv
`default_nettype none
module imhdk_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imhdk_pkg::status_t sts_i,
  output imhdk_pkg::cmd_t    cmd_o
);
  import imhdk_pkg::*;

  state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (sts_i.accept) state_d = sts_i.is_pop ? ST_PRD : ST_URD;
      end
      ST_URD:   state_d = sts_i.pt_ok ? ST_UDEC : ST_DONE;
      ST_UDEC:  state_d = (sts_i.do_lower || sts_i.do_insert) ? ST_SUCHK : ST_DONE;
      ST_SUCHK: state_d = sts_i.pos_zero ? ST_PLACE : ST_SURP;
      ST_SURP:  state_d = ST_SUCMP;
      ST_SUCMP: state_d = sts_i.up_stop ? ST_PLACE : ST_SUCHK;
      ST_PRD:   state_d = sts_i.cnt_zero ? ST_DONE : ST_PTOP;
      ST_PTOP:  state_d = sts_i.cnt_one ? ST_DONE : ST_PLAST;
      ST_PLAST: state_d = ST_PKEY;
      ST_PKEY:  state_d = ST_SDCHK;
      ST_SDCHK: state_d = sts_i.at_leaf ? ST_PLACE : ST_SDL;
      ST_SDL:   state_d = ST_SDR;
      ST_SDR:   state_d = sts_i.has_right ? ST_SDRR : ST_SDCMP;
      ST_SDRR:  state_d = ST_SDCMP;
      ST_SDCMP: state_d = sts_i.down_stop ? ST_PLACE : ST_SDCHK;
      ST_PLACE: state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Issue datapath operation
  always_comb begin
    case (state_q)
      ST_CLEAR: cmd_o.op = OP_CLEAR;
      ST_IDLE:  cmd_o.op = OP_IDLE;
      ST_URD:   cmd_o.op = OP_URD;
      ST_UDEC:  cmd_o.op = OP_UDEC;
      ST_SUCHK: cmd_o.op = OP_SUCHK;
      ST_SURP:  cmd_o.op = OP_SURP;
      ST_SUCMP: cmd_o.op = OP_SUCMP;
      ST_PRD:   cmd_o.op = OP_PRD;
      ST_PTOP:  cmd_o.op = OP_PTOP;
      ST_PLAST: cmd_o.op = OP_PLAST;
      ST_PKEY:  cmd_o.op = OP_PKEY;
      ST_SDCHK: cmd_o.op = OP_SDCHK;
      ST_SDL:   cmd_o.op = OP_SDL;
      ST_SDR:   cmd_o.op = OP_SDR;
      ST_SDRR:  cmd_o.op = OP_SDRR;
      ST_SDCMP: cmd_o.op = OP_SDCMP;
      ST_PLACE: cmd_o.op = OP_PLACE;
      ST_DONE:  cmd_o.op = OP_DONE;
      default:  cmd_o.op = OP_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// File: design/imhdk_dp.sv
`default_nettype none
module imhdk_dp #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imhdk_pkg::cmd_t     cmd_i,
  output imhdk_pkg::status_t  sts_o,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [9:0]          point_index_i,
  input  logic [31:0]         reach_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [9:0]          popped_point_o,
  output logic                list_empty_o,
  output imhdk_pkg::act_e     update_action_o,
  output logic [10:0]         queue_count_o
);
  import imhdk_pkg::*;

  localparam int unsigned NPTS = (CAPACITY < 1024) ? CAPACITY : 1024;
  localparam int unsigned PW   = $clog2(NPTS);
  localparam int unsigned CW   = $clog2(NPTS + 1);
  localparam int unsigned SW   = PW + 2;

  // Memories: heap position -> point, point -> reach, point -> {tag, position}
  logic [PW-1:0] slot_mem  [NPTS];
  logic [31:0]   reach_mem [NPTS];
  logic [SW-1:0] stat_mem  [NPTS];

  logic          slot_we, reach_we, stat_we;
  logic [PW-1:0] slot_wa, reach_wa, stat_wa;
  logic [PW-1:0] slot_wd;
  logic [31:0]   reach_wd;
  logic [SW-1:0] stat_wd;
  logic [PW-1:0] slot_ra, reach_ra, stat_ra;
  logic [PW-1:0] slot_rd_q;
  logic [31:0]   reach_rd_q;
  logic [SW-1:0] stat_rd_q;

  // Control registers
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] clr_q;
  logic          out_valid_q;

  // Working registers
  logic          req_q;
  logic [9:0]    pt_q;
  logic [31:0]   key_q;
  logic [PW-1:0] pos_q;
  logic [PW-1:0] upt_q;
  logic [PW-1:0] c_q;
  logic [PW-1:0] cpt_q;
  logic [31:0]   ckey_q;
  logic [PW-1:0] popped_q;
  logic          empty_q;
  act_e          act_q;

  // Result registers
  logic [9:0]    popped_out_q;
  logic          empty_out_q;
  act_e          act_out_q;
  logic [10:0]   cnt_out_q;

  logic          accept;
  logic          queued;
  logic [PW-1:0] parent;
  logic [PW-1:0] child;
  logic [PW-1:0] pt_idx;
  logic          right_less;

  assign accept     = in_valid_i && (cmd_i.op == OP_IDLE);
  assign in_ready_o = (cmd_i.op == OP_IDLE);
  assign queued     = (stat_rd_q[SW-1 -: 2] == TAG_QUEUED);
  assign parent     = (pos_q - PW'(1)) >> 1;
  assign child      = PW'({pos_q, 1'b1});
  assign pt_idx     = pt_q[PW-1:0];
  assign right_less = (reach_rd_q < ckey_q);

  // Status back to the sequencer
  always_comb begin
    sts_o.accept    = accept;
    sts_o.is_pop    = req_type_i;
    sts_o.clr_last  = (clr_q == PW'(NPTS - 1));
    sts_o.pt_ok     = ({1'b0, pt_q} < 11'(NPTS));
    sts_o.do_lower  = queued && (key_q < reach_rd_q);
    sts_o.do_insert = !queued && (cnt_q < CW'(NPTS));
    sts_o.pos_zero  = (pos_q == '0);
    sts_o.up_stop   = (reach_rd_q <= key_q);
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.cnt_one   = (cnt_q == CW'(1));
    sts_o.at_leaf   = (CW'(pos_q) >= (cnt_q >> 1));
    sts_o.has_right = ((CW'(c_q) + CW'(1)) < cnt_q);
    sts_o.down_stop = (key_q <= ckey_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Memory addressing per operation
  always_comb begin
    slot_we  = 1'b0;
    slot_wa  = pos_q;
    slot_wd  = pt_idx;
    reach_we = 1'b0;
    reach_wa = pt_idx;
    reach_wd = key_q;
    stat_we  = 1'b0;
    stat_wa  = pt_idx;
    stat_wd  = {TAG_QUEUED, pos_q};
    slot_ra  = '0;
    reach_ra = pt_idx;
    stat_ra  = pt_idx;
    case (cmd_i.op)
      OP_CLEAR: begin
        stat_we = 1'b1;
        stat_wa = clr_q;
        stat_wd = {TAG_UNVISITED, PW'(0)};
      end
      OP_UDEC: begin
        reach_we = sts_o.do_lower || sts_o.do_insert;
      end
      OP_SUCHK: slot_ra = parent;
      OP_SURP:  reach_ra = slot_rd_q;
      OP_SUCMP: begin
        slot_we = !sts_o.up_stop;
        slot_wd = upt_q;
        stat_we = !sts_o.up_stop;
        stat_wa = upt_q;
      end
      OP_PTOP: begin
        stat_we = 1'b1;
        stat_wa = slot_rd_q;
        stat_wd = {TAG_PROCESSED, PW'(0)};
        slot_ra = PW'(cnt_q - CW'(1));
      end
      OP_PLAST: reach_ra = slot_rd_q;
      OP_SDCHK: slot_ra = child;
      OP_SDL: begin
        reach_ra = slot_rd_q;
        slot_ra  = c_q + PW'(1);
      end
      OP_SDR:   reach_ra = slot_rd_q;
      OP_SDCMP: begin
        slot_we = !sts_o.down_stop;
        slot_wd = cpt_q;
        stat_we = !sts_o.down_stop;
        stat_wa = cpt_q;
      end
      OP_PLACE: begin
        slot_we = 1'b1;
        stat_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Memory ports with registered reads
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (reach_we) reach_mem[reach_wa] <= reach_wd;
    reach_rd_q <= reach_mem[reach_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    stat_rd_q <= stat_mem[stat_ra];
  end

  // Control registers: count, clear sweep, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + PW'(1);
      if (cmd_i.op == OP_UDEC && sts_o.do_insert) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.op == OP_PTOP) cnt_q <= cnt_q - CW'(1);
      if (cmd_i.op == OP_DONE && sts_o.out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_IDLE: begin
        if (accept) begin
          req_q    <= req_type_i;
          pt_q     <= point_index_i;
          key_q    <= reach_value_i;
          popped_q <= '0;
          empty_q  <= 1'b0;
          act_q    <= req_type_i ? ACT_POP : ACT_SAME;
        end
      end
      OP_UDEC: begin
        if (sts_o.do_lower) begin
          pos_q <= stat_rd_q[PW-1:0];
          act_q <= ACT_LOWER;
        end else if (sts_o.do_insert) begin
          pos_q <= PW'(cnt_q);
          act_q <= ACT_INSERT;
        end
      end
      OP_SURP: upt_q <= slot_rd_q;
      OP_SUCMP: if (!sts_o.up_stop) pos_q <= parent;
      OP_PRD: if (sts_o.cnt_zero) empty_q <= 1'b1;
      OP_PTOP: popped_q <= slot_rd_q;
      OP_PLAST: pt_q <= 10'(slot_rd_q);
      OP_PKEY: begin
        key_q <= reach_rd_q;
        pos_q <= '0;
      end
      OP_SDCHK: c_q <= child;
      OP_SDL: cpt_q <= slot_rd_q;
      OP_SDR: begin
        ckey_q <= reach_rd_q;
        upt_q  <= slot_rd_q;
      end
      OP_SDRR: begin
        if (right_less) begin
          ckey_q <= reach_rd_q;
          cpt_q  <= upt_q;
          c_q    <= c_q + PW'(1);
        end
      end
      OP_SDCMP: if (!sts_o.down_stop) pos_q <= c_q;
      default: ;
    endcase
  end

  // Load result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DONE && sts_o.out_free) begin
      popped_out_q <= 10'(popped_q);
      empty_out_q  <= empty_q && req_q;
      act_out_q    <= act_q;
      cnt_out_q    <= 11'(cnt_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign popped_point_o  = popped_out_q;
  assign list_empty_o    = empty_out_q;
  assign update_action_o = act_out_q;
  assign queue_count_o   = cnt_out_q;

endmodule
`default_nettype wire

// File: tb/sv/indexed_min_heap_decrease_key_tb.sv
module indexed_min_heap_decrease_key_tb;
  import imhdk_pkg::*;

  localparam int unsigned NPTS        = 1024;
  localparam int unsigned PT_DONE     = NPTS;
  localparam int unsigned PT_FRESH    = NPTS + 1;
  localparam int unsigned STALL_LIMIT = 6000;

  typedef struct {
    logic [9:0]  popped;
    logic        empty;
    act_e        action;
    logic [10:0] count;
  } heap_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [9:0]  point_index_i = '0;
  logic [31:0] reach_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  popped_point_o;
  logic        list_empty_o;
  logic [1:0]  update_action_o;
  logic [10:0] queue_count_o;

  // Mirror of the heap contents
  logic [9:0]  slot_pt [NPTS];
  logic [31:0] pt_reach [NPTS];
  int unsigned pt_pos [NPTS];
  int unsigned heap_size;

  heap_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  bit           calm = 1'b0;
  int unsigned  ready_hold = 0;

  indexed_min_heap_decrease_key dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .point_index_i,
    .reach_value_i, .out_valid_o, .out_ready_i, .popped_point_o, .list_empty_o,
    .update_action_o, .queue_count_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Move point upward while its parent holds a larger reach
  task automatic climb(input int unsigned pos, input logic [9:0] pt);
    int unsigned up;
    logic [9:0] upt;
    while (pos > 0) begin
      up = (pos - 1) >> 1;
      upt = slot_pt[up];
      if (pt_reach[upt] <= pt_reach[pt]) break;
      slot_pt[pos] = upt;
      pt_pos[upt] = pos;
      pos = up;
    end
    slot_pt[pos] = pt;
    pt_pos[pt] = pos;
  endtask

  // Place point at root and sink it; left child wins ties
  task automatic sink(input logic [9:0] pt);
    int unsigned pos, c;
    logic [9:0] cpt;
    logic [31:0] ckey;
    pos = 0;
    while (pos < (heap_size >> 1)) begin
      c = 2 * pos + 1;
      cpt = slot_pt[c];
      ckey = pt_reach[cpt];
      if (c + 1 < heap_size && pt_reach[slot_pt[c+1]] < ckey) begin
        c = c + 1;
        cpt = slot_pt[c];
        ckey = pt_reach[cpt];
      end
      if (pt_reach[pt] <= ckey) break;
      slot_pt[pos] = cpt;
      pt_pos[cpt] = pos;
      pos = c;
    end
    slot_pt[pos] = pt;
    pt_pos[pt] = pos;
  endtask

  // Apply one transaction to the mirror and queue its expected result
  task automatic apply_heap_op(input logic pop, input logic [9:0] pt, input logic [31:0] r);
    heap_result_t res;
    res.popped = '0;
    res.empty = 1'b0;
    if (pop) begin
      res.action = ACT_POP;
      if (heap_size == 0) begin
        res.empty = 1'b1;
      end else begin
        res.popped = slot_pt[0];
        pt_pos[slot_pt[0]] = PT_DONE;
        heap_size--;
        if (heap_size > 0) sink(slot_pt[heap_size]);
      end
    end else begin
      res.action = ACT_SAME;
      if (pt_pos[pt] < NPTS) begin
        if (r < pt_reach[pt]) begin
          pt_reach[pt] = r;
          climb(pt_pos[pt], pt);
          res.action = ACT_LOWER;
        end
      end else if (heap_size < NPTS) begin
        pt_reach[pt] = r;
        heap_size++;
        climb(heap_size - 1, pt);
        res.action = ACT_INSERT;
      end
    end
    res.count = heap_size[10:0];
    pending_results.push_back(res);
  endtask

  // Send one transaction, with an occasional idle burst ahead of it
  task automatic send_item(input logic pop, input logic [9:0] pt, input logic [31:0] r);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = pop;
    point_index_i = pt;
    reach_value_i = r;
    do @(posedge clk_i); while (!in_ready_o);
    apply_heap_op(pop, pt, r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);
  endtask

  // Empty heap, both key extremes, lowering, ties, reinsertion of popped point
  task automatic test_directed();
    send_item(1'b1, 10'd0, 32'd0);
    send_item(1'b0, 10'd1023, 32'hFFFF_FFFF);
    send_item(1'b0, 10'd0, 32'd0);
    send_item(1'b0, 10'd1023, 32'd5);
    send_item(1'b0, 10'd1023, 32'd5);
    send_item(1'b0, 10'd1023, 32'd9);
    send_item(1'b0, 10'd5, 32'd7);
    send_item(1'b0, 10'd6, 32'd7);
    send_item(1'b0, 10'd7, 32'd7);
    send_item(1'b0, 10'd8, 32'd7);
    send_item(1'b0, 10'd8, 32'd0);
    send_item(1'b0, 10'd682, 32'h8000_0000);
    send_item(1'b0, 10'd341, 32'h7FFF_FFFF);
    repeat (9) send_item(1'b1, 10'd0, 32'd0);
    send_item(1'b0, 10'd0, 32'd3);
    send_item(1'b1, 10'd0, 32'd0);
    send_item(1'b1, 10'd0, 32'd0);
  endtask

  // Mixed updates and pops, mostly over a small point pool, with a drained pause midway
  task automatic test_random_mix(input int unsigned n);
    int unsigned k, sel;
    logic [9:0] pt;
    logic [31:0] r;
    for (k = 0; k < n; k++) begin
      if (k == n / 2) drain_results();
      sel = $urandom_range(0, 99);
      pt = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
      case ($urandom_range(0, 2))
        0: r = $urandom;
        1: r = $urandom_range(0, 15);
        default: r = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
      endcase
      if (sel < 35) send_item(1'b1, 10'($urandom), 32'($urandom));
      else send_item(1'b0, pt, r);
    end
  endtask

  // Grow a deep heap, then drain it completely
  task automatic test_fill_drain(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_item(1'b0, 10'($urandom), $urandom_range(0, 255));
    for (k = 0; k < n / 4; k++) send_item(1'b0, 10'($urandom), $urandom_range(0, 200));
    while (heap_size > 0) send_item(1'b1, 10'($urandom), 32'($urandom));
    send_item(1'b1, 10'd0, 32'd0);
  endtask

  // Output stall bursts
  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      out_ready_i = 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i = 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      ready_hold = $urandom_range(1, 18) - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result popped=%0d action=%0d", $time,
                 popped_point_o, update_action_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (popped_point_o !== want.popped) begin
          $display("%0t: popped_point expected %0d actual %0d", $time, want.popped,
                   popped_point_o);
          error_count++;
        end
        if (list_empty_o !== want.empty) begin
          $display("%0t: list_empty expected %0d actual %0d", $time, want.empty,
                   list_empty_o);
          error_count++;
        end
        if (update_action_o !== want.action) begin
          $display("%0t: update_action expected %0d actual %0d", $time, want.action,
                   update_action_o);
          error_count++;
        end
        if (queue_count_o !== want.count) begin
          $display("%0t: queue_count expected %0d actual %0d", $time, want.count,
                   queue_count_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("indexed_min_heap_decrease_key verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    for (k = 0; k < NPTS; k++) begin
      pt_pos[k] = PT_FRESH;
      pt_reach[k] = '0;
      slot_pt[k] = '0;
    end
    heap_size = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_mix(450);
    test_fill_drain(300);
    calm = 1'b1;
    test_random_mix(250);
    drain_results();
    repeat (150) @(posedge clk_i);
    if (error_count == 0) $display("indexed_min_heap_decrease_key verification clean");
    else $display("indexed_min_heap_decrease_key verification failed");
    $finish;
  end

endmodule
